[rtl/udph_pkg.sv]
package udph_pkg;

   localparam int POSITION_BITS = 16;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_BITS = 2;
   localparam int FIFO_CNT_BITS = 3;

   localparam logic [15:0] TAG_TYPE  = 16'h8100;
   localparam logic [15:0] IPV4_TYPE = 16'h0800;
   localparam logic [7:0]  PROTO_UDP = 8'd17;

   localparam int POS_TYPE_HI     = 12;
   localparam int POS_TYPE_LO     = 13;
   localparam int POS_INNER_HI    = 16;
   localparam int POS_INNER_LO    = 17;
   localparam int POS_IP_PLAIN    = 14;
   localparam int POS_IP_TAGGED   = 18;
   localparam int PROTO_OFFSET    = 9;
   localparam int UDP_HDR_BYTES   = 8;
   localparam int MIN_IP_HDR      = 20;

   localparam logic [7:0] CHAR_LOW  = 8'd32;
   localparam logic [7:0] CHAR_HIGH = 8'd126;
   localparam logic [7:0] CHAR_TAB  = 8'd9;
   localparam logic [7:0] CHAR_DOT  = 8'd46;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [15:0] udp_length;
      logic [15:0] udp_checksum;
      logic [7:0]  display_char;
      logic        last_of_run;
   } result_type;

   function automatic logic [7:0] show_byte(input logic [7:0] b);
      logic [7:0] r;
      if ((b >= CHAR_LOW && b <= CHAR_HIGH) || b == CHAR_TAB) r = b;
      else r = CHAR_DOT;
      return r;
   endfunction

endpackage

[rtl/udp_packet_header_parser_top.sv]
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | data_byte, last_byte
// rsp     | out       | rsp_valid/rsp_stall | kind, ports, length, checksum, char, last_of_run
//
// One frame byte is taken per cycle while req_stall is low; its results are written
// into a 4-entry output queue; rsp gives one result per cycle while rsp_stall is low.
// A byte can cause two results (header or payload char, then end item), so
// req_stall rises while fewer than two queue slots are free.
// Synchronous active-high reset clears parser state and empties the queue.
module udp_packet_header_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_source_port,
   output logic [15:0] rsp_destination_port,
   output logic [15:0] rsp_udp_length,
   output logic [15:0] rsp_udp_checksum,
   output logic [7:0]  rsp_display_char,
   output logic        rsp_last_of_run
);
   import udph_pkg::*;

   localparam int PB = POSITION_BITS;

   logic [PB-1:0] pos_ff, pos_in;
   logic [15:0]   type_ff, type_in;
   logic          tagged_ff, tagged_in;
   logic [5:0]    ihb_ff, ihb_in;
   logic          dropped_ff, dropped_in;
   logic [15:0]   hf_ff [4];
   logic [15:0]   hf_in [4];
   logic [15:0]   remain_ff, remain_in;
   logic          emitted_ff, emitted_in;

   result_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_BITS-1:0] count_ff, count_in;

   logic       req_fire, rsp_fire;
   logic       first_v, end_v;
   result_type first_r, end_r;

   logic [4:0]    ipb;
   logic [6:0]    hdr_start, hdr_end;
   logic [PB-1:0] start_ext, end_ext, k_diff;
   logic [2:0]    k;
   logic [15:0]   type_next, f3_next;

   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign req_stall = count_ff > FIFO_CNT_BITS'(FIFO_DEPTH - 2);
   assign rsp_valid = count_ff != '0;

   always_comb begin
      ipb       = tagged_ff ? 5'(POS_IP_TAGGED) : 5'(POS_IP_PLAIN);
      hdr_start = {2'b00, ipb} + {1'b0, ihb_ff};
      hdr_end   = hdr_start + 7'(UDP_HDR_BYTES);
      start_ext = {{(PB-7){1'b0}}, hdr_start};
      end_ext   = {{(PB-7){1'b0}}, hdr_end};
      k_diff    = pos_ff - start_ext;
      k         = k_diff[2:0];
      type_next = {type_ff[7:0], req_data_byte};
      f3_next   = {hf_ff[3][7:0], req_data_byte};
   end

   always_comb begin
      pos_in     = (pos_ff != '1) ? pos_ff + 1'b1 : pos_ff;
      type_in    = type_ff;
      tagged_in  = tagged_ff;
      ihb_in     = ihb_ff;
      dropped_in = dropped_ff;
      hf_in      = hf_ff;
      remain_in  = remain_ff;
      emitted_in = emitted_ff;
      first_v    = 1'b0;
      first_r    = '0;
      end_r      = '0;

      if (emitted_ff) begin
         if (remain_ff != '0) begin
            first_v              = 1'b1;
            first_r.kind         = KIND_PAYLOAD;
            first_r.display_char = show_byte(req_data_byte);
            remain_in            = remain_ff - 16'd1;
         end
      end else if (!dropped_ff) begin
         if (pos_ff == PB'(POS_TYPE_HI) || pos_ff == PB'(POS_TYPE_LO) ||
             (tagged_ff && (pos_ff == PB'(POS_INNER_HI) || pos_ff == PB'(POS_INNER_LO))))
            type_in = type_next;

         if (pos_ff == PB'(POS_TYPE_LO)) begin
            if (type_next == TAG_TYPE) tagged_in = 1'b1;
            else if (type_next != IPV4_TYPE) dropped_in = 1'b1;
         end else if (pos_ff == PB'(POS_INNER_LO) && tagged_ff) begin
            if (type_next != IPV4_TYPE) dropped_in = 1'b1;
         end else if (pos_ff >= PB'(POS_IP_PLAIN) && pos_ff == PB'(ipb)) begin
            ihb_in = {req_data_byte[3:0], 2'b00};
            if (ihb_in < 6'(MIN_IP_HDR)) dropped_in = 1'b1;
         end else if (pos_ff >= PB'(POS_IP_PLAIN) && pos_ff == PB'(ipb) + PB'(PROTO_OFFSET)) begin
            if (req_data_byte != PROTO_UDP) dropped_in = 1'b1;
         end else if (pos_ff >= PB'(POS_IP_PLAIN) && ihb_ff >= 6'(MIN_IP_HDR) &&
                      pos_ff >= start_ext && pos_ff < end_ext) begin
            hf_in[k[2:1]] = {hf_ff[k[2:1]][7:0], req_data_byte};
            if (k == 3'd7) begin
               first_v                  = 1'b1;
               first_r.kind             = KIND_HEADER;
               first_r.source_port      = hf_ff[0];
               first_r.destination_port = hf_ff[1];
               first_r.udp_length       = hf_ff[2];
               first_r.udp_checksum     = f3_next;
               emitted_in               = 1'b1;
               remain_in = (hf_ff[2] >= 16'(UDP_HDR_BYTES)) ?
                           hf_ff[2] - 16'(UDP_HDR_BYTES) : 16'd0;
            end
         end
      end

      end_v               = req_last_byte && emitted_in;
      end_r.kind          = KIND_END;
      end_r.last_of_run   = 1'b1;
      first_r.last_of_run = !end_v;

      if (req_last_byte) begin
         pos_in     = '0;
         type_in    = '0;
         tagged_in  = 1'b0;
         ihb_in     = '0;
         dropped_in = 1'b0;
         for (int i = 0; i < 4; i++) hf_in[i] = '0;
         remain_in  = '0;
         emitted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         type_ff    <= '0;
         tagged_ff  <= 1'b0;
         ihb_ff     <= '0;
         dropped_ff <= 1'b0;
         for (int i = 0; i < 4; i++) hf_ff[i] <= '0;
         remain_ff  <= '0;
         emitted_ff <= 1'b0;
      end else if (req_fire) begin
         pos_ff     <= pos_in;
         type_ff    <= type_in;
         tagged_ff  <= tagged_in;
         ihb_ff     <= ihb_in;
         dropped_ff <= dropped_in;
         hf_ff      <= hf_in;
         remain_ff  <= remain_in;
         emitted_ff <= emitted_in;
      end
   end

   // output queue: up to two pushes and one pop per cycle
   always_comb begin
      count_in = count_ff;
      if (req_fire)
         count_in = count_in + FIFO_CNT_BITS'(first_v) + FIFO_CNT_BITS'(end_v);
      if (rsp_fire)
         count_in = count_in - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (rsp_fire) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (req_fire)
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_BITS'(first_v) + FIFO_PTR_BITS'(end_v);
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         if (first_v) begin
            mem_ff[wr_ptr_ff] <= first_r;
            if (end_v) mem_ff[wr_ptr_ff + 1'b1] <= end_r;
         end else if (end_v) begin
            mem_ff[wr_ptr_ff] <= end_r;
         end
      end
   end

   assign rsp_kind             = mem_ff[rd_ptr_ff].kind;
   assign rsp_source_port      = mem_ff[rd_ptr_ff].source_port;
   assign rsp_destination_port = mem_ff[rd_ptr_ff].destination_port;
   assign rsp_udp_length       = mem_ff[rd_ptr_ff].udp_length;
   assign rsp_udp_checksum     = mem_ff[rd_ptr_ff].udp_checksum;
   assign rsp_display_char     = mem_ff[rd_ptr_ff].display_char;
   assign rsp_last_of_run      = mem_ff[rd_ptr_ff].last_of_run;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FIFO_CNT_BITS'(FIFO_DEPTH))
      else $error("output queue overflow");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last_byte) |=> (pos_ff == '0 && !emitted_ff && !dropped_ff))
      else $error("frame state not cleared after last byte");

   a_emit_not_dropped: assert property (@(posedge clock) disable iff (reset)
      emitted_ff |-> !dropped_ff)
      else $error("header emitted on a dropped frame");

   a_payload_after_header: assert property (@(posedge clock) disable iff (reset)
      (remain_ff != '0) |-> emitted_ff)
      else $error("payload count without header");
endmodule
